// ===== rtl/bsor_pkg.sv =====
// Shared types and constants for the bin scatter owner router.
// No dependencies; every other file but bsor_fifo imports this package.
package bsor_pkg;

  localparam int BINS_W     = 13;
  localparam int CORES_W    = 7;
  localparam int SLOT_W     = 6;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Restoring-division steps done in each divider stage.
  localparam int DIV_STEPS = 4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CELL = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINS_X     = 2'd0,
    CFG_BINS_Y     = 2'd1,
    CFG_CORE_COUNT = 2'd2,
    CFG_SLAB_BASE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    op_e               func;
    logic [SLOT_W-1:0] table_slot;
    logic [31:0]       packed_coord;
    logic [15:0]       bin_x;
    logic [15:0]       bin_y;
    logic [31:0]       area;
  } in_item_t;

  typedef struct packed {
    logic [15:0] owner_x;
    logic [15:0] owner_y;
    logic [31:0] local_addr;
    logic [31:0] increment;
  } out_item_t;

endpackage

// ===== rtl/bsor_front.sv =====
// Front end: accepts items, drops out-of-range and zero-area cells, forms the global bin
// and divides it by the core count in a pipelined divider. Uses bsor_pkg.
module bsor_front #(
  parameter int MAX_CORES     = 64,
  parameter int MAX_BINS_AXIS = 4096,
  parameter int QDEPTH        = 15,
  localparam int OwnW  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1,
  localparam int BinW  = $clog2(MAX_BINS_AXIS),
  localparam int GlobW = 2 * BinW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bsor_pkg::in_item_t            in_item_i,
  input  logic [bsor_pkg::BINS_W-1:0]   bins_x_i,
  input  logic [bsor_pkg::BINS_W-1:0]   bins_y_i,
  input  logic [bsor_pkg::CORES_W-1:0]  core_count_i,
  input  logic                          pop_i,
  output logic                          push_o,
  output bsor_pkg::op_e                 op_o,
  output logic [bsor_pkg::SLOT_W-1:0]   slot_o,
  output logic [bsor_pkg::DATA_W-1:0]   data_o,
  output logic [OwnW-1:0]               owner_o,
  output logic [GlobW-1:0]              quot_o
);
  import bsor_pkg::*;

  localparam int NbW  = $clog2(MAX_BINS_AXIS + 1);
  localparam int NcW  = $clog2(MAX_CORES + 1);
  localparam int NStg = (GlobW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int CntW = $clog2(QDEPTH + 1);

  // Effective geometry after saturation.
  logic [NbW-1:0] nbx, nby;
  logic [NcW-1:0] nc;

  assign nbx = (32'(bins_x_i) > 32'(MAX_BINS_AXIS)) ? NbW'(MAX_BINS_AXIS) : NbW'(bins_x_i);
  assign nby = (32'(bins_y_i) > 32'(MAX_BINS_AXIS)) ? NbW'(MAX_BINS_AXIS) : NbW'(bins_y_i);
  assign nc  = (core_count_i == '0) ? NcW'(1) :
               (32'(core_count_i) > 32'(MAX_CORES)) ? NcW'(MAX_CORES) : NcW'(core_count_i);

  // Credits: items in the pipe plus items in the queue.
  logic [CntW-1:0] inflight_q, inflight_d;
  logic            keep, launch;

  assign keep = (in_item_i.func == OP_LOAD) ||
                ((32'(in_item_i.bin_x) < 32'(nbx)) && (32'(in_item_i.bin_y) < 32'(nby)) &&
                 (in_item_i.area != '0));
  assign in_ready_o = (inflight_q < CntW'(QDEPTH));
  assign launch     = in_valid_i && in_ready_o && keep;
  assign inflight_d = inflight_q + CntW'(launch) - CntW'(pop_i);

  // Stage 1: captured item
  logic              s1_vld_q;
  op_e               s1_op_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic [DATA_W-1:0] s1_data_q;
  logic [BinW-1:0]   s1_bx_q, s1_by_q;
  // Stage 2: product
  logic              s2_vld_q;
  op_e               s2_op_q;
  logic [SLOT_W-1:0] s2_slot_q;
  logic [DATA_W-1:0] s2_data_q;
  logic [GlobW-1:0]  s2_prod_q;
  logic [BinW-1:0]   s2_by_q;
  // Stage 3: global bin
  logic              s3_vld_q;
  op_e               s3_op_q;
  logic [SLOT_W-1:0] s3_slot_q;
  logic [DATA_W-1:0] s3_data_q;
  logic [GlobW-1:0]  s3_glob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      s1_vld_q   <= launch;
      s2_vld_q   <= s1_vld_q;
      s3_vld_q   <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q   <= in_item_i.func;
    s1_slot_q <= in_item_i.table_slot;
    s1_data_q <= (in_item_i.func == OP_LOAD) ? in_item_i.packed_coord : in_item_i.area;
    s1_bx_q   <= BinW'(in_item_i.bin_x);
    s1_by_q   <= BinW'(in_item_i.bin_y);

    s2_op_q   <= s1_op_q;
    s2_slot_q <= s1_slot_q;
    s2_data_q <= s1_data_q;
    s2_prod_q <= GlobW'(s1_bx_q) * GlobW'(nby);
    s2_by_q   <= s1_by_q;

    s3_op_q   <= s2_op_q;
    s3_slot_q <= s2_slot_q;
    s3_data_q <= s2_data_q;
    s3_glob_q <= s2_prod_q + GlobW'(s2_by_q);
  end

  // Divider: num shifts out dividend bits and takes quotient bits in.
  logic              div_vld_q  [NStg];
  op_e               div_op_q   [NStg];
  logic [SLOT_W-1:0] div_slot_q [NStg];
  logic [DATA_W-1:0] div_data_q [NStg];
  logic [GlobW-1:0]  div_num_q  [NStg];
  logic [NcW-1:0]    div_rem_q  [NStg];

  for (genvar s = 0; s < NStg; s++) begin : g_div
    logic              vld_in;
    op_e               op_in;
    logic [SLOT_W-1:0] slot_in;
    logic [DATA_W-1:0] data_in;
    logic [GlobW-1:0]  num_in, num_nx;
    logic [NcW-1:0]    rem_in, rem_nx;

    if (s == 0) begin : g_first
      assign vld_in  = s3_vld_q;
      assign op_in   = s3_op_q;
      assign slot_in = s3_slot_q;
      assign data_in = s3_data_q;
      assign num_in  = s3_glob_q;
      assign rem_in  = '0;
    end else begin : g_next
      assign vld_in  = div_vld_q[s-1];
      assign op_in   = div_op_q[s-1];
      assign slot_in = div_slot_q[s-1];
      assign data_in = div_data_q[s-1];
      assign num_in  = div_num_q[s-1];
      assign rem_in  = div_rem_q[s-1];
    end

    always_comb begin
      logic [NcW:0] trial;
      num_nx = num_in;
      rem_nx = rem_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (s * DIV_STEPS + k < GlobW) begin
          trial  = {rem_nx, num_nx[GlobW-1]};
          num_nx = num_nx << 1;
          if (trial >= {1'b0, nc}) begin
            rem_nx    = NcW'(trial - {1'b0, nc});
            num_nx[0] = 1'b1;
          end else begin
            rem_nx = NcW'(trial);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[s] <= 1'b0;
      end else begin
        div_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      div_op_q[s]   <= op_in;
      div_slot_q[s] <= slot_in;
      div_data_q[s] <= data_in;
      div_num_q[s]  <= num_nx;
      div_rem_q[s]  <= rem_nx;
    end
  end

  assign push_o  = div_vld_q[NStg-1];
  assign op_o    = div_op_q[NStg-1];
  assign slot_o  = div_slot_q[NStg-1];
  assign data_o  = div_data_q[NStg-1];
  assign owner_o = OwnW'(div_rem_q[NStg-1]);
  assign quot_o  = div_num_q[NStg-1];

endmodule

// ===== rtl/bsor_fifo.sv =====
// Small show-ahead queue between the front and back ends.
// Generic width and depth; no package dependency.
module bsor_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  assign not_empty_o = (count_q != '0);
  assign rdata_o     = mem_q[rd_ptr_q];

endmodule

// ===== rtl/bsor_back.sv =====
// Back end: applies table loads, looks up owner coordinates and drives
// the result register. Uses bsor_pkg.
module bsor_back #(
  parameter int MAX_CORES     = 64,
  parameter int MAX_BINS_AXIS = 4096,
  localparam int OwnW  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1,
  localparam int GlobW = 2 * $clog2(MAX_BINS_AXIS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_vld_i,
  input  bsor_pkg::op_e                head_op_i,
  input  logic [bsor_pkg::SLOT_W-1:0]  head_slot_i,
  input  logic [bsor_pkg::DATA_W-1:0]  head_data_i,
  input  logic [OwnW-1:0]              head_owner_i,
  input  logic [GlobW-1:0]             head_quot_i,
  output logic                         pop_o,
  input  logic [31:0]                  slab_base_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bsor_pkg::out_item_t          out_item_o
);
  import bsor_pkg::*;

  logic [31:0] tbl_q [MAX_CORES];
  logic [31:0] word_q;
  logic [31:0] addr_q;
  logic [31:0] incr_q;
  logic        res_vld_q;
  logic        take_cell;

  // Loads never wait on the result register; cells need it free.
  assign pop_o     = head_vld_i && ((head_op_i == OP_LOAD) || !res_vld_q || out_ready_i);
  assign take_cell = pop_o && (head_op_i == OP_CELL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (take_cell) begin
      res_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (head_op_i == OP_LOAD) && (32'(head_slot_i) < 32'(MAX_CORES))) begin
      tbl_q[OwnW'(head_slot_i)] <= head_data_i;
    end
    if (take_cell) begin
      word_q <= tbl_q[head_owner_i];
      addr_q <= slab_base_i + (32'(head_quot_i) << 2);
      incr_q <= head_data_i;
    end
  end

  assign out_valid_o           = res_vld_q;
  assign out_item_o.owner_x    = word_q[15:0];
  assign out_item_o.owner_y    = word_q[31:16];
  assign out_item_o.local_addr = addr_q;
  assign out_item_o.increment  = incr_q;

endmodule

// ===== rtl/bin_scatter_owner_router.sv =====
// Bin scatter owner router, top level: configuration registers, front end,
// queue and back end. Uses bsor_pkg, bsor_front, bsor_fifo and bsor_back.
//
// Usage:
//   in channel   in_valid_i / in_ready_o / in_item_i. func OP_LOAD writes
//                packed_coord into owner table entry table_slot; OP_CELL
//                routes a density contribution. Cells out of range or with
//                zero area are dropped at the door and produce nothing.
//   out channel  out_valid_o / out_ready_i / out_item_o, one transaction
//                per surviving cell, in input order.
//   cfg channel  cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i.
//                Always ready; write only while the block is drained.
// Pipeline: capture, product and global-bin registers, then DivStg
//   divider stages, each retiring DIV_STEPS quotient bits of the global
//   bin, then the queue and the result register.
// Throughput: one item per cycle while in_ready_o is high. in_ready_o comes
//   from a credit counter sized to the queue depth, so the pipe itself never
//   stalls; a stalled receiver fills the queue and then in_ready_o drops.
// Reset: config returns to one bin per axis, one core, base zero; all
//   valids and credits clear. The owner table is not cleared: load an entry
//   before any cell that maps to it.
module bin_scatter_owner_router #(
  parameter int MAX_CORES     = 64,
  parameter int MAX_BINS_AXIS = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bsor_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bsor_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsor_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsor_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bsor_pkg::*;

  localparam int OwnW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int GlobW  = 2 * $clog2(MAX_BINS_AXIS);
  localparam int DivStg = (GlobW + DIV_STEPS - 1) / DIV_STEPS;
  // Covers the whole credit round trip with some slack.
  localparam int QDepth = DivStg + 7;
  localparam int QW     = 1 + SLOT_W + DATA_W + OwnW + GlobW;

  // Configuration registers
  logic [BINS_W-1:0]  bins_x_q, bins_y_q;
  logic [CORES_W-1:0] core_count_q;
  logic [31:0]        slab_base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_x_q     <= BINS_W'(1);
      bins_y_q     <= BINS_W'(1);
      core_count_q <= CORES_W'(1);
      slab_base_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BINS_X:     bins_x_q     <= cfg_data_i[BINS_W-1:0];
        CFG_BINS_Y:     bins_y_q     <= cfg_data_i[BINS_W-1:0];
        CFG_CORE_COUNT: core_count_q <= cfg_data_i[CORES_W-1:0];
        CFG_SLAB_BASE:  slab_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end -> queue
  logic              f_push;
  op_e               f_op;
  logic [SLOT_W-1:0] f_slot;
  logic [DATA_W-1:0] f_data;
  logic [OwnW-1:0]   f_owner;
  logic [GlobW-1:0]  f_quot;
  logic              q_pop;

  bsor_front #(
    .MAX_CORES     (MAX_CORES),
    .MAX_BINS_AXIS (MAX_BINS_AXIS),
    .QDEPTH        (QDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .bins_x_i     (bins_x_q),
    .bins_y_i     (bins_y_q),
    .core_count_i (core_count_q),
    .pop_i        (q_pop),
    .push_o       (f_push),
    .op_o         (f_op),
    .slot_o       (f_slot),
    .data_o       (f_data),
    .owner_o      (f_owner),
    .quot_o       (f_quot)
  );

  // Queue entry: op, slot, data, owner, quotient.
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              q_not_empty;
  logic              h_op_bit;
  logic [SLOT_W-1:0] h_slot;
  logic [DATA_W-1:0] h_data;
  logic [OwnW-1:0]   h_owner;
  logic [GlobW-1:0]  h_quot;

  assign q_wdata = {(f_op == OP_CELL), f_slot, f_data, f_owner, f_quot};
  assign {h_op_bit, h_slot, h_data, h_owner, h_quot} = q_rdata;

  bsor_fifo #(
    .WIDTH (QW),
    .DEPTH (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .wdata_i     (q_wdata),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .rdata_o     (q_rdata)
  );

  bsor_back #(
    .MAX_CORES     (MAX_CORES),
    .MAX_BINS_AXIS (MAX_BINS_AXIS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_vld_i   (q_not_empty),
    .head_op_i    (h_op_bit ? OP_CELL : OP_LOAD),
    .head_slot_i  (h_slot),
    .head_data_i  (h_data),
    .head_owner_i (h_owner),
    .head_quot_i  (h_quot),
    .pop_o        (q_pop),
    .slab_base_i  (slab_base_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== rtl/bsor_checker.sv =====
// Port-level checks for the bin scatter owner router, bound to the top.
// Uses bsor_pkg for the result type.
module bsor_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bsor_pkg::out_item_t out_item_o
);
  import bsor_pkg::*;

  // Nothing can reach the output the first edge after reset.
  a_no_result_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // Credits are full after reset, so input is open.
  a_ready_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> in_ready_o)
    else $error("input not ready right after reset");

  // Zero-area cells are dropped, so no result carries a zero increment.
  a_nonzero_increment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.increment != '0))
    else $error("result with zero increment");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind bin_scatter_owner_router bsor_checker u_bsor_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/sv/tb.sv =====
// Testbench for bin_scatter_owner_router: directed and random item streams
// checked against a local predictor of owner lookup and slab addressing.
// Depends on bsor_pkg and the RTL of the router.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsor_pkg::*;

  localparam int MAX_CORES     = 64;
  localparam int MAX_BINS_AXIS = 4096;
  // Settle longer than the pipe takes to empty before reconfiguring.
  localparam int DRAIN_CYCLES  = 24;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 84;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bin_scatter_owner_router #(
    .MAX_CORES    (MAX_CORES),
    .MAX_BINS_AXIS(MAX_BINS_AXIS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the register file and the owner coordinate table.
  logic [BINS_W-1:0]  bins_x_q;
  logic [BINS_W-1:0]  bins_y_q;
  logic [CORES_W-1:0] cores_q;
  logic [DATA_W-1:0]  slab_base_q;
  logic [31:0]        owner_words [MAX_CORES];

  // Routes predicted at input acceptance, oldest first.
  out_item_t pending_routes [$];

  int error_count = 0;
  // When set, neither side idles: back-to-back transactions.
  bit steady = 1'b0;
  // Receiver stall cycles left.
  int hold = 0;

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  // Applies one item to the shadow state; returns 1 with the route it yields.
  function automatic bit route_item(input in_item_t it, output out_item_t res);
    int unsigned     nbx;
    int unsigned     nby;
    int unsigned     nc;
    longint unsigned gbin;
    longint unsigned slot;
    logic [31:0]     word;
    res = '0;
    if (it.func == OP_LOAD) begin
      if (it.table_slot < MAX_CORES) owner_words[it.table_slot] = it.packed_coord;
      return 1'b0;
    end
    nbx = clamp_count(32'(bins_x_q), MAX_BINS_AXIS);
    nby = clamp_count(32'(bins_y_q), MAX_BINS_AXIS);
    nc  = clamp_count(32'(cores_q), MAX_CORES);
    if (nc == 0) nc = 1;
    // Out-of-range bins (zero bin count included) and zero area are dropped.
    if (it.bin_x >= nbx || it.bin_y >= nby || it.area == '0) return 1'b0;
    gbin = longint'(it.bin_x) * nby + it.bin_y;
    slot = gbin / nc;
    word = owner_words[SLOT_W'(gbin % nc)];
    res.owner_x    = word[15:0];
    res.owner_y    = word[31:16];
    res.local_addr = slab_base_q + 32'(slot << 2);   // wraps at 32 bits
    res.increment  = it.area;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Sends one item; called at a clock edge, returns at its acceptance edge.
  // valid is only lowered when a gap is drawn, so no edge carries two
  // assignments to it.
  task automatic send_item(input in_item_t it);
    int        gap;
    out_item_t res;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (route_item(it, res)) pending_routes.push_back(res);
  endtask

  // Holds the sender until every predicted route has come out, then lets
  // the pipe settle, since dropped cells leave no trace to wait on.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BINS_X:     bins_x_q    = data[BINS_W-1:0];
      CFG_BINS_Y:     bins_y_q    = data[BINS_W-1:0];
      CFG_CORE_COUNT: cores_q     = data[CORES_W-1:0];
      CFG_SLAB_BASE:  slab_base_q = data[DATA_W-1:0];
      default: ;
    endcase
    // Drop valid on its own edge so a following write cannot collide.
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reconfigures only once the block is idle.
  task automatic apply_setting(input logic [31:0] bx, input logic [31:0] by,
                               input logic [31:0] nc, input logic [31:0] base);
    wait_drained();
    write_reg(CFG_BINS_X, bx);
    write_reg(CFG_BINS_Y, by);
    write_reg(CFG_CORE_COUNT, nc);
    write_reg(CFG_SLAB_BASE, base);
  endtask

  function automatic in_item_t make_cell(input logic [15:0] bx, input logic [15:0] by,
                                         input logic [31:0] area);
    in_item_t it;
    it              = '0;
    it.func         = OP_CELL;
    it.table_slot   = SLOT_W'($urandom_range(0, 63));
    it.packed_coord = $urandom;
    it.bin_x        = bx;
    it.bin_y        = by;
    it.area         = area;
    return it;
  endfunction

  function automatic in_item_t make_load(input logic [SLOT_W-1:0] slot,
                                         input logic [31:0] word);
    in_item_t it;
    it              = make_cell(16'($urandom), 16'($urandom), $urandom);
    it.func         = OP_LOAD;
    it.table_slot   = slot;
    it.packed_coord = word;
    return it;
  endfunction

  // Random item under the current setting: mostly in-range cells with
  // random content, some full-width noise, zero areas and table loads.
  function automatic in_item_t random_item(input int unsigned load_pct);
    in_item_t    it;
    int unsigned nbx;
    int unsigned nby;
    it = make_cell(16'($urandom), 16'($urandom), $urandom);
    if ($urandom_range(0, 99) < load_pct) begin
      it.func = OP_LOAD;
      return it;
    end
    nbx = clamp_count(32'(bins_x_q), MAX_BINS_AXIS);
    nby = clamp_count(32'(bins_y_q), MAX_BINS_AXIS);
    if (nbx > 0 && $urandom_range(0, 7) != 0) it.bin_x = 16'($urandom_range(0, nbx - 1));
    if (nby > 0 && $urandom_range(0, 7) != 0) it.bin_y = 16'($urandom_range(0, nby - 1));
    if ($urandom_range(0, 9) == 0) it.area = '0;
    return it;
  endfunction

  function automatic logic [31:0] draw_bins();
    case ($urandom_range(0, 11))
      0:       return 0;
      1, 2:    return 1;
      3:       return MAX_BINS_AXIS;
      4:       return $urandom_range(MAX_BINS_AXIS + 1, 8191);
      5:       return $urandom_range(1, MAX_BINS_AXIS);
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  function automatic logic [31:0] draw_cores();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return MAX_CORES;
      3:       return $urandom_range(MAX_CORES + 1, 127);
      default: return $urandom_range(1, MAX_CORES);
    endcase
  endfunction

  function automatic logic [31:0] draw_base();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FF00;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Each output transaction is matched against the oldest predicted route;
  // after each one the receiver draws a stall, and stalls now and then
  // even while nothing is offered.
  always @(posedge clk_i) begin : sink
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_routes.size() == 0) begin
        $error("output transaction with no route pending: %p", out_item_o);
        error_count++;
      end else begin
        want = pending_routes.pop_front();
        check_field("owner_x", 32'(want.owner_x), 32'(out_item_o.owner_x));
        check_field("owner_y", 32'(want.owner_y), 32'(out_item_o.owner_y));
        check_field("local_addr", want.local_addr, out_item_o.local_addr);
        check_field("increment", want.increment, out_item_o.increment);
      end
      hold = steady ? 0 : $urandom_range(0, 3);
    end else if (hold > 0) begin
      hold--;
    end else if (!steady && $urandom_range(0, 15) == 0) begin
      hold = $urandom_range(1, 3);
    end
    out_ready_i <= rst_ni && (hold == 0);
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset setting: a single bin on a single core, base zero.
  task automatic test_reset_defaults();
    send_item(make_load(0, 32'hFFFF_FFFF));
    send_item(make_cell(0, 0, 32'h0000_0001));
    send_item(make_cell(0, 0, 32'hFFFF_FFFF));
    send_item(make_cell(1, 0, 5));              // x out of range
    send_item(make_cell(0, 1, 5));              // y out of range
    send_item(make_cell(0, 0, 0));              // zero area
    send_item(make_cell(16'hFFFF, 16'hFFFF, 1));
    send_item(make_load(0, 32'h0000_0000));
    send_item(make_cell(0, 0, 7));
  endtask

  // Writes every owner entry in shuffled order so no cell can reach an
  // unwritten one; the two ends get the extreme words.
  task automatic test_table_fill();
    int       order [MAX_CORES];
    int       j;
    int       t;
    in_item_t it;
    for (int i = 0; i < MAX_CORES; i++) order[i] = i;
    for (int i = MAX_CORES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < MAX_CORES; i++) begin
      it            = random_item(100);
      it.table_slot = SLOT_W'(order[i]);
      send_item(it);
    end
    send_item(make_load(SLOT_W'(MAX_CORES - 1), 32'hFFFF_FFFF));
    send_item(make_load(0, 32'h0000_0000));
  endtask

  // Largest grid, most cores, base near the top so addresses wrap.
  task automatic test_extremes();
    apply_setting(MAX_BINS_AXIS, MAX_BINS_AXIS, MAX_CORES, 32'hFFFF_FFFC);
    send_item(make_cell(4095, 4095, 32'hFFFF_FFFF));
    send_item(make_cell(0, 0, 1));
    send_item(make_cell(4095, 0, 3));
    send_item(make_cell(0, 4095, 2));
    send_item(make_cell(4096, 0, 1));
    send_item(make_cell(0, 4096, 1));
  endtask

  // Counts above the limits saturate; a zero core count acts as one core.
  task automatic test_saturation();
    apply_setting(8191, 8191, 127, 32'h8000_0000);
    send_item(make_cell(4095, 4095, 9));
    send_item(make_cell(4096, 1, 9));
    send_item(make_cell(63, 64, 9));
    apply_setting(5, 7, 0, 16);
    send_item(make_cell(4, 6, 1));
    send_item(make_cell(0, 0, 2));
  endtask

  // A zero bin count on either axis drops every cell; a 3x3 grid then passes one.
  task automatic test_zero_bins();
    apply_setting(0, 3, 4, 0);
    send_item(make_cell(0, 0, 1));
    apply_setting(3, 0, 4, 0);
    send_item(make_cell(0, 0, 1));
    apply_setting(3, 3, 4, 0);
    send_item(make_cell(2, 2, 1));
  endtask

  // One random setting and a stream of random items under it.
  task automatic test_random_phase(input int n_items, input bit no_idle,
                                   input bit mid_pause);
    apply_setting(draw_bins(), draw_bins(), draw_cores(), draw_base());
    steady = no_idle;
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) wait_drained();
      send_item(random_item(15));
    end
    steady = 1'b0;
  endtask

  initial begin : run
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BINS_X;
    cfg_data_i  = '0;
    bins_x_q    = BINS_W'(1);
    bins_y_q    = BINS_W'(1);
    cores_q     = CORES_W'(1);
    slab_base_q = '0;
    for (int i = 0; i < MAX_CORES; i++) owner_words[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_table_fill();
    test_extremes();
    test_saturation();
    test_zero_bins();
    for (int p = 0; p < PHASES; p++) test_random_phase(PHASE_ITEMS, p == 2, p == 4);

    wait_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run (a few tens of microseconds).
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
